// ===== src/cpis_pkg.sv =====
// cpis_pkg: shared types and constants for the code point interval set
// op codes, controller states, command and status structs
// no dependencies
`timescale 1ns / 1ps

package cpis_pkg;

  // field widths fixed by the interface
  localparam int CP_W    = 21;
  localparam int BOUND_W = 22;
  localparam int TOTAL_W = 7;

  // highest code point
  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  // operation codes, code 3 is unused
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_CMP  = 2'd1,
    OP_DUMP = 2'd2
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINAL,
    ST_RESP,
    ST_SIMPLE,
    ST_DUMP_START,
    ST_DUMP_DATA
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic init_walk;   // latch bounds, clear write count
    logic walk_cmp;    // walk is a complement, not an add
    logic clr_rd;      // clear read index
    logic rd_en;       // read held table at read index
    logic walk_proc;   // process read data as one walk step
    logic final_wr;    // write the closing entry of the walk
    logic commit_resp; // commit if it fits, load op result
    logic load_simple; // load a plain result, table unchanged
    logic dump_load;   // load one dumped range
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_valid;    // read data valid this cycle
    logic rd_done;     // read index reached the held count
    logic out_free;    // output register can take a result
    logic outside;     // add request lies outside the code space
    logic empty;       // no ranges held
  } sts_t;

endpackage

// ===== src/cpis_ctrl.sv =====
// cpis_ctrl: operation sequencer for the code point interval set
// drives datapath commands from op code and datapath status
// depends on cpis_pkg
`timescale 1ns / 1ps

module cpis_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      op,
  input  cpis_pkg::sts_t  sts,
  output cpis_pkg::cmd_t  cmd
);

  cpis_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      cpis_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((op == cpis_pkg::OP_ADD && !sts.outside) || op == cpis_pkg::OP_CMP) begin
            cmd.init_walk = 1'b1;
            cmd.walk_cmp  = (op == cpis_pkg::OP_CMP);
            cmd.clr_rd    = 1'b1;
            state_next    = cpis_pkg::ST_WALK;
          end else if (op == cpis_pkg::OP_DUMP && !sts.empty) begin
            cmd.clr_rd = 1'b1;
            state_next = cpis_pkg::ST_DUMP_START;
          end else begin
            state_next = cpis_pkg::ST_SIMPLE;
          end
        end
      end
      // stream held ranges through the merge or complement logic
      cpis_pkg::ST_WALK: begin
        cmd.rd_en     = !sts.rd_done;
        cmd.walk_proc = sts.rd_valid;
        if (sts.rd_done && !sts.rd_valid) begin
          state_next = cpis_pkg::ST_FINAL;
        end
      end
      cpis_pkg::ST_FINAL: begin
        cmd.final_wr = 1'b1;
        state_next   = cpis_pkg::ST_RESP;
      end
      cpis_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.commit_resp = 1'b1;
          state_next      = cpis_pkg::ST_IDLE;
        end
      end
      cpis_pkg::ST_SIMPLE: begin
        if (sts.out_free) begin
          cmd.load_simple = 1'b1;
          state_next      = cpis_pkg::ST_IDLE;
        end
      end
      cpis_pkg::ST_DUMP_START: begin
        cmd.rd_en  = 1'b1;
        state_next = cpis_pkg::ST_DUMP_DATA;
      end
      // one range per cycle while the output drains
      cpis_pkg::ST_DUMP_DATA: begin
        if (sts.out_free) begin
          cmd.dump_load = 1'b1;
          if (sts.rd_done) begin
            state_next = cpis_pkg::ST_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_next = cpis_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/cpis_dpath.sv =====
// cpis_dpath: range table banks, merge and complement stream, output register
// two table banks: one holds the set, the other takes the rebuilt set
// depends on cpis_pkg
`timescale 1ns / 1ps

module cpis_dpath #(
  parameter int MAX_RANGES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [cpis_pkg::BOUND_W-1:0]  range_a,
  input  logic signed [cpis_pkg::BOUND_W-1:0]  range_b,
  input  cpis_pkg::cmd_t                       cmd,
  output cpis_pkg::sts_t                       sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cpis_pkg::CP_W-1:0]            out_first,
  output logic [cpis_pkg::CP_W-1:0]            out_last,
  output logic [cpis_pkg::TOTAL_W-1:0]         range_total,
  output logic                                 set_empty,
  output logic                                 status,
  output logic                                 is_last
);

  localparam int AW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW    = $clog2(MAX_RANGES + 1);
  localparam int NW    = $clog2(MAX_RANGES + 2);
  localparam int DEPTH = 2 * (1 << AW);
  localparam int CPW   = cpis_pkg::CP_W;
  localparam int BW    = cpis_pkg::BOUND_W;

  localparam logic signed [BW-1:0] CP_MAX_S = BW'(cpis_pkg::CP_MAX);
  localparam logic [BW-1:0]        CP_MAX_U = BW'(cpis_pkg::CP_MAX);

  // table memory, one entry is {first, last}
  logic [2*CPW-1:0] mem [DEPTH];

  logic              bank;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_idx;
  logic              rd_valid;
  logic [2*CPW-1:0]  rd_data;
  logic [NW-1:0]     n;
  logic              is_cmp;
  logic              placed;
  logic [CPW-1:0]    nlo, nhi;
  logic [CPW-1:0]    held_f, held_l;
  logic [BW-1:0]     gap_lo;

  logic signed [BW-1:0] lo_s, hi_s;
  logic [CPW-1:0]       clamp_lo, clamp_hi;
  logic [CPW-1:0]       f, l;
  logic [BW-1:0]        f_ext, l_inc, nhi_inc;
  logic                 below, after;
  logic                 wr_req, wr_en;
  logic [CPW-1:0]       wr_first, wr_last;
  logic [AW:0]          wr_addr, rd_addr;
  logic                 fits;
  logic [CW-1:0]        new_count;

  // order and clamp the requested bounds
  always_comb begin
    lo_s     = (range_a < range_b) ? range_a : range_b;
    hi_s     = (range_a < range_b) ? range_b : range_a;
    clamp_lo = (lo_s < 0) ? '0 : lo_s[CPW-1:0];
    clamp_hi = (hi_s > CP_MAX_S) ? cpis_pkg::CP_MAX : hi_s[CPW-1:0];
  end

  // held entry compared against the range being merged
  always_comb begin
    f       = rd_data[2*CPW-1:CPW];
    l       = rd_data[CPW-1:0];
    f_ext   = {1'b0, f};
    l_inc   = {1'b0, l} + BW'(1);
    nhi_inc = {1'b0, nhi} + BW'(1);
    below   = l_inc < {1'b0, nlo};
    after   = f_ext > nhi_inc;
  end

  // entry to write into the spare bank
  always_comb begin
    wr_req   = 1'b0;
    wr_first = nlo;
    wr_last  = nhi;
    if (cmd.walk_proc) begin
      if (is_cmp) begin
        if (f_ext > gap_lo) begin
          wr_req   = 1'b1;
          wr_first = gap_lo[CPW-1:0];
          wr_last  = f - CPW'(1);
        end
      end else if (placed) begin
        wr_req   = 1'b1;
        wr_first = held_f;
        wr_last  = held_l;
      end else if (below) begin
        wr_req   = 1'b1;
        wr_first = f;
        wr_last  = l;
      end else if (after) begin
        wr_req = 1'b1;
      end
    end else if (cmd.final_wr) begin
      if (is_cmp) begin
        if (gap_lo <= CP_MAX_U) begin
          wr_req   = 1'b1;
          wr_first = gap_lo[CPW-1:0];
          wr_last  = cpis_pkg::CP_MAX;
        end
      end else begin
        wr_req = 1'b1;
        if (placed) begin
          wr_first = held_f;
          wr_last  = held_l;
        end
      end
    end
  end

  assign wr_en     = wr_req && (n < NW'(MAX_RANGES));
  assign wr_addr   = {~bank, n[AW-1:0]};
  assign rd_addr   = {bank, rd_idx[AW-1:0]};
  assign fits      = n <= NW'(MAX_RANGES);
  assign new_count = fits ? CW'(n) : count;

  // table memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_first, wr_last};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // read index and read data valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.clr_rd) begin
        rd_idx <= '0;
      end else if (cmd.rd_en) begin
        rd_idx <= rd_idx + CW'(1);
      end
    end
  end

  // merge and complement walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      n      <= '0;
      placed <= 1'b0;
      is_cmp <= 1'b0;
    end else if (cmd.init_walk) begin
      n      <= '0;
      placed <= 1'b0;
      is_cmp <= cmd.walk_cmp;
    end else begin
      if (wr_req) begin
        n <= n + NW'(1);
      end
      if (cmd.walk_proc && !is_cmp && !placed && !below && after) begin
        placed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_walk) begin
      nlo    <= clamp_lo;
      nhi    <= clamp_hi;
      gap_lo <= '0;
    end else if (cmd.walk_proc) begin
      if (is_cmp) begin
        gap_lo <= l_inc;
      end else if (placed || (!below && after)) begin
        held_f <= f;
        held_l <= l;
      end else if (!below) begin
        // overlapping or touching: widen the merged range
        if (f < nlo) nlo <= f;
        if (l > nhi) nhi <= l;
      end
    end
  end

  // active bank and held count, swapped on a commit that fits
  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      count <= '0;
    end else if (cmd.commit_resp && fits) begin
      bank  <= ~bank;
      count <= CW'(n);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit_resp || cmd.load_simple || cmd.dump_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_resp) begin
      out_first   <= '0;
      out_last    <= '0;
      range_total <= cpis_pkg::TOTAL_W'(new_count);
      set_empty   <= (new_count == '0);
      status      <= !fits;
      is_last     <= 1'b1;
    end else if (cmd.load_simple) begin
      out_first   <= '0;
      out_last    <= '0;
      range_total <= cpis_pkg::TOTAL_W'(count);
      set_empty   <= (count == '0);
      status      <= 1'b0;
      is_last     <= 1'b1;
    end else if (cmd.dump_load) begin
      out_first   <= f;
      out_last    <= l;
      range_total <= cpis_pkg::TOTAL_W'(count);
      set_empty   <= (count == '0);
      status      <= 1'b0;
      is_last     <= (rd_idx == count);
    end
  end

  // status to the controller
  always_comb begin
    sts.rd_valid = rd_valid;
    sts.rd_done  = (rd_idx == count);
    sts.out_free = !out_valid || out_ready;
    sts.outside  = (hi_s < 0) || (lo_s > CP_MAX_S);
    sts.empty    = (count == '0);
  end

endmodule

// ===== src/code_point_interval_set.sv =====
// code_point_interval_set: top level of the sorted code point range set
// joins the sequencer cpis_ctrl and the table datapath cpis_dpath
// depends on cpis_pkg, cpis_ctrl, cpis_dpath
//
//   port group   | dir | signals
//   -------------+-----+-------------------------------------------------------
//   input item   | in  | in_valid, in_ready, op, range_a, range_b
//   result item  | out | out_valid, out_ready, out_first, out_last,
//                |     | range_total, set_empty, status, is_last
//
// add and complement read the held ranges, one table read per cycle through the
// single read port, drain the last read, then make a closing write and the
// commit. dump gives one range per cycle while the output takes them, after a
// first read. other items load a plain result. one item is in work at a time;
// a waiting result does not block the next accept. reset empties the set, the
// tables need no clearing. a stalled output holds the sequencer in its result
// or dump state.
`timescale 1ns / 1ps

module code_point_interval_set #(
  parameter int MAX_RANGES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           op,
  input  logic signed [cpis_pkg::BOUND_W-1:0]  range_a,
  input  logic signed [cpis_pkg::BOUND_W-1:0]  range_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cpis_pkg::CP_W-1:0]            out_first,
  output logic [cpis_pkg::CP_W-1:0]            out_last,
  output logic [cpis_pkg::TOTAL_W-1:0]         range_total,
  output logic                                 set_empty,
  output logic                                 status,
  output logic                                 is_last
);

  cpis_pkg::cmd_t cmd;
  cpis_pkg::sts_t sts;

  // sequencer
  cpis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd)
  );

  // range tables and result register
  cpis_dpath #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .range_a     (range_a),
    .range_b     (range_b),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_first   (out_first),
    .out_last    (out_last),
    .range_total (range_total),
    .set_empty   (set_empty),
    .status      (status),
    .is_last     (is_last)
  );

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for code_point_interval_set
// keeps its own copy of the range table, drives random and directed items
// depends on cpis_pkg and the code_point_interval_set rtl
`timescale 1ns / 1ps

module tb;

  localparam int MAX_RANGES   = 64;
  localparam int CP_W         = cpis_pkg::CP_W;
  localparam int TOTAL_W      = cpis_pkg::TOTAL_W;
  localparam int BOUND_W      = cpis_pkg::BOUND_W;
  localparam int CODE_TOP     = int'(cpis_pkg::CP_MAX);
  localparam int BOUND_MIN    = -2097152;
  localparam int BOUND_MAX    = 2097151;
  localparam int SLOT         = 17000;
  localparam int RANDOM_ITEMS = 190;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;

  // op code 3 has no enum member in the package
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // one result item as seen on the output port
  typedef struct packed {
    logic [CP_W-1:0]    span_first;
    logic [CP_W-1:0]    span_last;
    logic [TOTAL_W-1:0] total;
    logic               empty;
    logic               refused;
    logic               tail;
  } range_result_t;

  // range table shadow plus the queue of results still owed by the block
  class interval_scoreboard;
    logic [CP_W-1:0] lo_tab [MAX_RANGES];
    logic [CP_W-1:0] hi_tab [MAX_RANGES];
    int              held;
    int              work_lo [MAX_RANGES+1];
    int              work_hi [MAX_RANGES+1];
    range_result_t   due_results [$];
    int              errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // totals always reflect the set after the item
    function void queue_result(int f, int l, bit st, bit fin);
      range_result_t r;
      r.span_first = f[CP_W-1:0];
      r.span_last  = l[CP_W-1:0];
      r.total      = held[TOTAL_W-1:0];
      r.empty      = (held == 0);
      r.refused    = st;
      r.tail       = fin;
      due_results  = {due_results, r};
    endfunction

    function void commit_work(int n);
      for (int i = 0; i < n; i++) begin
        lo_tab[i] = work_lo[i][CP_W-1:0];
        hi_tab[i] = work_hi[i][CP_W-1:0];
      end
      held = n;
    endfunction

    // sorted insert that joins overlapping or touching ranges, 1 when refused
    function bit merge_range(int a, int b);
      int  lo;
      int  hi;
      int  f;
      int  l;
      int  n;
      bit  placed;
      lo     = (a < b) ? a : b;
      hi     = (a < b) ? b : a;
      n      = 0;
      placed = 1'b0;
      if (hi < 0 || lo > CODE_TOP) return 1'b0;
      if (lo < 0) lo = 0;
      if (hi > CODE_TOP) hi = CODE_TOP;
      for (int i = 0; i < held; i++) begin
        f = int'(lo_tab[i]);
        l = int'(hi_tab[i]);
        if (l + 1 < lo) begin
          work_lo[n] = f;
          work_hi[n] = l;
          n++;
        end else if (f > hi + 1) begin
          if (!placed) begin
            work_lo[n] = lo;
            work_hi[n] = hi;
            n++;
            placed = 1'b1;
          end
          work_lo[n] = f;
          work_hi[n] = l;
          n++;
        end else begin
          if (f < lo) lo = f;
          if (l > hi) hi = l;
        end
      end
      if (!placed) begin
        work_lo[n] = lo;
        work_hi[n] = hi;
        n++;
      end
      if (n > MAX_RANGES) return 1'b1;
      commit_work(n);
      return 1'b0;
    endfunction

    // inverse over the whole code space, 1 when refused
    function bit invert_set();
      int n;
      n = 0;
      if (held == 0) begin
        work_lo[0] = 0;
        work_hi[0] = CODE_TOP;
        n = 1;
      end else begin
        if (lo_tab[0] != '0) begin
          work_lo[n] = 0;
          work_hi[n] = int'(lo_tab[0]) - 1;
          n++;
        end
        for (int i = 1; i < held; i++) begin
          work_lo[n] = int'(hi_tab[i-1]) + 1;
          work_hi[n] = int'(lo_tab[i]) - 1;
          n++;
        end
        if (int'(hi_tab[held-1]) != CODE_TOP) begin
          work_lo[n] = int'(hi_tab[held-1]) + 1;
          work_hi[n] = CODE_TOP;
          n++;
        end
      end
      if (n > MAX_RANGES) return 1'b1;
      commit_work(n);
      return 1'b0;
    endfunction

    // accepted input item: update the shadow table, queue what it owes
    function void note_item(logic [1:0] code, logic signed [BOUND_W-1:0] ra,
                            logic signed [BOUND_W-1:0] rb);
      bit refused;
      refused = 1'b0;
      case (code)
        cpis_pkg::OP_ADD: refused = merge_range(int'(ra), int'(rb));
        cpis_pkg::OP_CMP: refused = invert_set();
        cpis_pkg::OP_DUMP: begin
          if (held == 0) begin
            queue_result(0, 0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < held; i++)
              queue_result(int'(lo_tab[i]), int'(hi_tab[i]), 1'b0, i == held - 1);
          end
          return;
        end
        default: ;
      endcase
      queue_result(0, 0, refused, 1'b1);
    endfunction

    function void compare_field(string name, logic [CP_W-1:0] want,
                                logic [CP_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // accepted result item against the oldest one owed
    function void check_result(range_result_t got);
      range_result_t want;
      if (due_results.size() == 0) begin
        $error("result item with none expected: out_first %0h out_last %0h",
               got.span_first, got.span_last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("out_first", want.span_first, got.span_first);
      compare_field("out_last", want.span_last, got.span_last);
      compare_field("range_total", CP_W'(want.total), CP_W'(got.total));
      compare_field("set_empty", CP_W'(want.empty), CP_W'(got.empty));
      compare_field("status", CP_W'(want.refused), CP_W'(got.refused));
      compare_field("is_last", CP_W'(want.tail), CP_W'(got.tail));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [1:0]                 op;
  logic signed [BOUND_W-1:0]  range_a;
  logic signed [BOUND_W-1:0]  range_b;
  logic                       out_valid;
  logic                       out_ready;
  logic [CP_W-1:0]            out_first;
  logic [CP_W-1:0]            out_last;
  logic [TOTAL_W-1:0]         range_total;
  logic                       set_empty;
  logic                       status;
  logic                       is_last;

  interval_scoreboard sb = new();
  int unsigned        cycles = 0;
  int                 items_sent = 0;
  int                 burst_left = 0;

  code_point_interval_set #(
    .MAX_RANGES(MAX_RANGES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .range_a    (range_a),
    .range_b    (range_b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_first  (out_first),
    .out_last   (out_last),
    .range_total(range_total),
    .set_empty  (set_empty),
    .status     (status),
    .is_last    (is_last)
  );

  // 12 ns clock
  always #6 clk = ~clk;

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL code_point_interval_set");
      $finish;
    end
  end

  // receiver: stall pattern switches among always ready, random and mostly stalled modes
  int ready_mode = 0;
  int ready_left = 0;
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(50, 300);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: results first, then the accepted input item
  always @(posedge clk) begin
    range_result_t seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen.span_first = out_first;
        seen.span_last  = out_last;
        seen.total      = range_total;
        seen.empty      = set_empty;
        seen.refused    = status;
        seen.tail       = is_last;
        sb.check_result(seen);
      end
      if (in_valid && in_ready)
        sb.note_item(op, range_a, range_b);
    end
  end

  // offer one item, hold it until accepted, then maybe idle
  task automatic send_item(input logic [1:0] code, input int a, input int b);
    int gap;
    in_valid <= 1'b1;
    op       <= code;
    range_a  <= a[BOUND_W-1:0];
    range_b  <= b[BOUND_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (code != OP_UNUSED) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // bound mix: whole field, near both ends of the space, outside, touching held ranges
  function automatic int pick_bound();
    int k;
    case ($urandom_range(0, 6))
      0: return int'($urandom_range(0, 4194303)) + BOUND_MIN;
      1: return int'($urandom_range(0, 400));
      2: return CODE_TOP - int'($urandom_range(0, 400));
      3: begin
        case ($urandom_range(0, 7))
          0:       return BOUND_MIN;
          1:       return BOUND_MAX;
          2:       return -1;
          3:       return 0;
          4:       return 1;
          5:       return CODE_TOP - 1;
          6:       return CODE_TOP;
          default: return CODE_TOP + 1;
        endcase
      end
      4: return int'($urandom_range(0, CODE_TOP));
      5: begin
        if ($urandom_range(0, 1))
          return -int'($urandom_range(1, 5000));
        return CODE_TOP + int'($urandom_range(1, 5000));
      end
      default: begin
        if (sb.held == 0) return int'($urandom_range(0, 400));
        k = $urandom_range(0, sb.held - 1);
        if ($urandom_range(0, 1)) return int'(sb.hi_tab[k]) + 1;
        return int'(sb.lo_tab[k]) - 1;
      end
    endcase
  endfunction

  // random mix of all operations, mostly narrow adds
  task automatic mixed_run(input int len);
    int pick;
    int a;
    int b;
    int t;
    repeat (len) begin
      pick = $urandom_range(0, 99);
      a = pick_bound();
      b = $urandom_range(0, 1) ? a + int'($urandom_range(0, 300)) : pick_bound();
      if ($urandom_range(0, 1)) begin
        t = a;
        a = b;
        b = t;
      end
      if (pick < 62)      send_item(cpis_pkg::OP_ADD, a, b);
      else if (pick < 74) send_item(cpis_pkg::OP_CMP, a, b);
      else if (pick < 92) send_item(cpis_pkg::OP_DUMP, a, b);
      else                send_item(OP_UNUSED, a, b);
    end
  endtask

  // empty the set, fill it with spaced ranges in random order, then push near or at capacity
  task automatic fill_table(input int want);
    int order [MAX_RANGES];
    int k;
    int t;
    int lo;
    int hi;
    send_item(cpis_pkg::OP_ADD, 0, CODE_TOP);
    send_item(cpis_pkg::OP_CMP, 0, 0);
    for (int i = 0; i < want; i++) order[i] = i;
    for (int i = want - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = order[i];
      order[i] = order[k];
      order[k] = t;
    end
    for (int i = 0; i < want; i++) begin
      lo = order[i] * SLOT + int'($urandom_range(50, 150));
      hi = lo + int'($urandom_range(0, 300));
      if ($urandom_range(0, 1)) send_item(cpis_pkg::OP_ADD, hi, lo);
      else send_item(cpis_pkg::OP_ADD, lo, hi);
    end
    // refused at a full table, otherwise the second one restores the set
    send_item(cpis_pkg::OP_CMP, 0, 0);
    send_item(cpis_pkg::OP_CMP, 0, 0);
    // new disjoint range between two held ones
    k = $urandom_range(0, want - 2);
    send_item(cpis_pkg::OP_ADD, k * SLOT + 9000,
              k * SLOT + 9000 + int'($urandom_range(0, 20)));
    send_item(cpis_pkg::OP_DUMP, 0, 0);
    // one wide range swallowing its neighbors
    send_item(cpis_pkg::OP_ADD, k * SLOT + 100, (k + 2) * SLOT + 200);
    send_item(cpis_pkg::OP_DUMP, 0, 0);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = cpis_pkg::OP_ADD;
    range_a   = '0;
    range_b   = '0;
    out_ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty set, unused code, complement both ways
    send_item(cpis_pkg::OP_DUMP, 0, 0);
    send_item(OP_UNUSED, 0, 0);
    send_item(cpis_pkg::OP_CMP, 0, 0);
    send_item(cpis_pkg::OP_DUMP, 0, 0);
    send_item(cpis_pkg::OP_CMP, 0, 0);
    // requests wholly outside the code space
    send_item(cpis_pkg::OP_ADD, -5, -1);
    send_item(cpis_pkg::OP_ADD, CODE_TOP + 1, BOUND_MAX);
    send_item(cpis_pkg::OP_ADD, BOUND_MIN, BOUND_MIN);
    // partly outside, clamped, bounds in either order
    send_item(cpis_pkg::OP_ADD, BOUND_MAX, CODE_TOP - 2);
    send_item(cpis_pkg::OP_ADD, BOUND_MIN, 3);
    // single point, touching both sides, spanning two ranges, one apart
    send_item(cpis_pkg::OP_ADD, 10, 10);
    send_item(cpis_pkg::OP_ADD, 4, 9);
    send_item(cpis_pkg::OP_ADD, 30, 20);
    send_item(cpis_pkg::OP_ADD, 40, 50);
    send_item(cpis_pkg::OP_ADD, 25, 45);
    send_item(cpis_pkg::OP_ADD, 12, 12);
    send_item(cpis_pkg::OP_DUMP, 0, 0);
    // ranges at both ends of the space
    send_item(cpis_pkg::OP_CMP, 0, 0);
    send_item(cpis_pkg::OP_DUMP, 0, 0);
    send_item(OP_UNUSED, BOUND_MAX, BOUND_MIN);
    send_item(cpis_pkg::OP_CMP, 0, 0);
    send_item(cpis_pkg::OP_DUMP, 0, 0);

    // random episodes, the first one runs the table to capacity
    items_sent = 0;
    fill_table(MAX_RANGES);
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        fill_table(($urandom_range(0, 1) == 0) ? MAX_RANGES : $urandom_range(62, 63));
      else
        mixed_run($urandom_range(10, 30));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS code_point_interval_set");
    else
      $display("FAIL code_point_interval_set");
    $finish;
  end

endmodule
